// ===== rtl/core/seqi_pkg.sv =====
// Shared types and constants for the sorted event queue.
package seqi_pkg;

   localparam int CAPACITY_BITS = 8;
   localparam logic [CAPACITY_BITS-1:0] CAPACITY_RESET = 8'd100;
   localparam int POS_BITS = 8;
   localparam int COUNT_BITS = 8;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_PLACE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   typedef struct packed {
      logic latch;        // capture the request key and the drop decision
      logic rd_first;     // read the last held entry
      logic step;         // move the entry just read up one slot, read the one below
      logic shift_last;   // move the front entry up one slot
      logic place_next;   // write the new key above the entry just read
      logic place_front;  // write the new key at the front
      logic load_out;     // load the response register
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic key_less;
      logic idx_zero;
      logic out_busy;
   } sts_type;

endpackage

// ===== rtl/core/sorted_event_queue_insert.sv =====
// Top level of the sorted event queue insert block.
// Each request beat inserts one event into a queue kept in ascending order of time, then
// value, after any equal entries, and returns one response beat with the drop flag, the
// 1-based position, the front entry and the entry count. An insert that finds the queue
// at capacity (the smaller of the capacity register and QUEUE_DEPTH) is refused; into an
// empty queue the key goes to the front; otherwise each held entry that sorts after the
// new event moves up one slot, then the key is written. The single entry RAM moves one
// entry per cycle: the scan runs from the back of the queue, reading the next entry down
// while writing the one read before it one slot up in the same cycle. The block takes
// one request at a time; a new request is taken while the previous response still waits.
// No clearing pass is needed after reset, as only entries below the count are read.
module sorted_event_queue_insert #(
   parameter int QUEUE_DEPTH = 128,
   parameter int TIME_BITS   = 16,
   parameter int VALUE_BITS  = 10
) (
   input  logic clock,
   input  logic reset,
   // Bits from lowest up: event_time, event_value, zero fill to whole bytes.
   input  logic [((TIME_BITS+VALUE_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // Bits from lowest up: dropped, insert_position, earliest_time, earliest_value,
   // entry_count, zero fill to whole bytes.
   output logic [((TIME_BITS+VALUE_BITS+17+7)/8)*8-1:0] rsp_tdata,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   input  logic                                         csr_write_en,
   input  logic [seqi_pkg::CAPACITY_BITS-1:0]           csr_write_data
);

   localparam int RSP_BITS = TIME_BITS + VALUE_BITS + 17;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   logic [seqi_pkg::CAPACITY_BITS-1:0] capacity_ff;
   seqi_pkg::cmd_type cmd;
   seqi_pkg::sts_type sts;
   logic                              req_fire;
   logic                              rsp_dropped;
   logic [seqi_pkg::POS_BITS-1:0]     rsp_position;
   logic [TIME_BITS-1:0]              rsp_time;
   logic [VALUE_BITS-1:0]             rsp_value;
   logic [seqi_pkg::COUNT_BITS-1:0]   rsp_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= seqi_pkg::CAPACITY_RESET;
      end else if (csr_write_en) begin
         capacity_ff <= csr_write_data;
      end
   end

   assign req_fire = req_tvalid & req_tready;

   seqi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .sts       (sts),
      .req_ready (req_tready),
      .cmd       (cmd)
   );

   seqi_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_BITS   (TIME_BITS),
      .VALUE_BITS  (VALUE_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .capacity     (capacity_ff),
      .req_time     (req_tdata[TIME_BITS-1:0]),
      .req_value    (req_tdata[TIME_BITS+VALUE_BITS-1:TIME_BITS]),
      .rsp_ready    (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_dropped  (rsp_dropped),
      .rsp_position (rsp_position),
      .rsp_time     (rsp_time),
      .rsp_value    (rsp_value),
      .rsp_count    (rsp_count)
   );

   assign rsp_tdata = RSP_W'({rsp_count, rsp_value, rsp_time, rsp_position, rsp_dropped});

   // At most one entry write is commanded in any cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.step, cmd.shift_last, cmd.place_next, cmd.place_front}))
      else $error("several entry writes commanded in one cycle");

   // A refused insert reports no position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_dropped |-> rsp_position == '0)
      else $error("dropped insert carries a position");

   // An accepted insert lands within the entries now held.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_dropped && QUEUE_DEPTH < 256 |->
         rsp_position != '0 && rsp_position <= rsp_count)
      else $error("insert position outside the held entries");

   // A request is only taken with the scan idle and no entry write pending.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |-> !(cmd.step || cmd.shift_last || cmd.place_next || cmd.place_front))
      else $error("request taken while an insert is in progress");

endmodule

// ===== rtl/core/seqi_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module seqi_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/seqi_ctrl.sv =====
// Controller state machine for the sorted event queue insert.
module seqi_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_fire,
   input  seqi_pkg::sts_type sts,
   output logic              req_ready,
   output seqi_pkg::cmd_type cmd
);

   seqi_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= seqi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         seqi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.latch = 1'b1;
               if (sts.full) begin
                  state_in = seqi_pkg::ST_DONE;
               end else if (sts.empty) begin
                  state_in = seqi_pkg::ST_PLACE;
               end else begin
                  cmd.rd_first = 1'b1;
                  state_in     = seqi_pkg::ST_SCAN;
               end
            end
         end
         seqi_pkg::ST_SCAN: begin
            // The read data belongs to the entry at the current index.
            if (sts.key_less) begin
               if (sts.idx_zero) begin
                  cmd.shift_last = 1'b1;
                  state_in       = seqi_pkg::ST_PLACE;
               end else begin
                  cmd.step = 1'b1;
               end
            end else begin
               cmd.place_next = 1'b1;
               state_in       = seqi_pkg::ST_DONE;
            end
         end
         seqi_pkg::ST_PLACE: begin
            cmd.place_front = 1'b1;
            state_in        = seqi_pkg::ST_DONE;
         end
         seqi_pkg::ST_DONE: begin
            if (!sts.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = seqi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = seqi_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/seqi_dp.sv =====
// Datapath: entry store, scan index, count, front entry and response register.
module seqi_dp #(
   parameter int QUEUE_DEPTH = 128,
   parameter int TIME_BITS   = 16,
   parameter int VALUE_BITS  = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  seqi_pkg::cmd_type                   cmd,
   output seqi_pkg::sts_type                   sts,
   input  logic [seqi_pkg::CAPACITY_BITS-1:0]  capacity,
   input  logic [TIME_BITS-1:0]                req_time,
   input  logic [VALUE_BITS-1:0]               req_value,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_dropped,
   output logic [seqi_pkg::POS_BITS-1:0]       rsp_position,
   output logic [TIME_BITS-1:0]                rsp_time,
   output logic [VALUE_BITS-1:0]               rsp_value,
   output logic [seqi_pkg::COUNT_BITS-1:0]     rsp_count
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_W = (CNT_W > seqi_pkg::CAPACITY_BITS) ? CNT_W : seqi_pkg::CAPACITY_BITS;
   localparam int KEY_W = TIME_BITS + VALUE_BITS;

   logic [TIME_BITS-1:0]  key_time_ff;
   logic [VALUE_BITS-1:0] key_value_ff;
   logic [CNT_W-1:0]      held_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [CNT_W-1:0]      pos_ff;
   logic                  dropped_ff;
   logic [TIME_BITS-1:0]  front_time_ff;
   logic [VALUE_BITS-1:0] front_value_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_dropped_ff;
   logic [seqi_pkg::POS_BITS-1:0]   rsp_position_ff;
   logic [TIME_BITS-1:0]            rsp_time_ff;
   logic [VALUE_BITS-1:0]           rsp_value_ff;
   logic [seqi_pkg::COUNT_BITS-1:0] rsp_count_ff;

   logic [CNT_W-1:0]      held_m1;
   logic [IDX_W-1:0]      idx_m1;
   logic [IDX_W-1:0]      idx_p1;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [KEY_W-1:0]      wr_data;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [KEY_W-1:0]      rd_data;
   logic [TIME_BITS-1:0]  rd_time;
   logic [VALUE_BITS-1:0] rd_value;
   logic                  commit;
   logic [CNT_W+7:0]      pos_wide;
   logic [CNT_W+7:0]      held_wide;

   seqi_ram #(
      .WIDTH (KEY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign held_m1  = held_ff - 1'b1;
   assign idx_m1   = idx_ff - 1'b1;
   assign idx_p1   = idx_ff + 1'b1;
   assign rd_time  = rd_data[TIME_BITS-1:0];
   assign rd_value = rd_data[KEY_W-1:TIME_BITS];

   assign rd_en   = cmd.rd_first | cmd.step;
   assign rd_addr = cmd.rd_first ? held_m1[IDX_W-1:0] : idx_m1;
   assign wr_en   = cmd.step | cmd.shift_last | cmd.place_next | cmd.place_front;
   assign wr_addr = cmd.place_front ? '0 : idx_p1;
   assign wr_data = (cmd.step | cmd.shift_last) ? rd_data : {key_value_ff, key_time_ff};
   assign commit  = cmd.place_next | cmd.place_front;

   assign sts.full     = (CMP_W'(held_ff) >= CMP_W'(capacity)) ||
                         (held_ff == CNT_W'(QUEUE_DEPTH));
   assign sts.empty    = (held_ff == '0);
   // Insertion goes after equal keys, so only a strictly greater entry moves up.
   assign sts.key_less = (key_time_ff < rd_time) ||
                         ((key_time_ff == rd_time) && (key_value_ff < rd_value));
   assign sts.idx_zero = (idx_ff == '0);
   assign sts.out_busy = rsp_valid_ff & ~rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            held_ff <= held_ff + 1'b1;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         key_time_ff  <= req_time;
         key_value_ff <= req_value;
         dropped_ff   <= sts.full;
         pos_ff       <= '0;
      end
      if (cmd.rd_first) begin
         idx_ff <= held_m1[IDX_W-1:0];
      end else if (cmd.step) begin
         idx_ff <= idx_m1;
      end
      if (cmd.place_next) begin
         pos_ff <= CNT_W'(idx_p1) + ((idx_p1 == '0) ? CNT_W'(QUEUE_DEPTH) : '0) + 1'b1;
      end else if (cmd.place_front) begin
         pos_ff         <= CNT_W'(1);
         front_time_ff  <= key_time_ff;
         front_value_ff <= key_value_ff;
      end
      if (cmd.load_out) begin
         rsp_dropped_ff  <= dropped_ff;
         rsp_position_ff <= pos_wide[seqi_pkg::POS_BITS-1:0];
         rsp_time_ff     <= sts.empty ? '0 : front_time_ff;
         rsp_value_ff    <= sts.empty ? '0 : front_value_ff;
         rsp_count_ff    <= held_wide[seqi_pkg::COUNT_BITS-1:0];
      end
   end

   assign pos_wide  = {8'd0, pos_ff};
   assign held_wide = {8'd0, held_ff};

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_dropped  = rsp_dropped_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_time     = rsp_time_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the sorted event queue insert block.
module tb_top;

   localparam int DEPTH     = 128;
   localparam int REQ_BITS  = 32;
   localparam int RSP_BITS  = 48;

   typedef struct {
      logic        dropped;
      logic [7:0]  position;
      logic [15:0] front_time;
      logic [9:0]  front_value;
      logic [7:0]  count;
   } insert_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [REQ_BITS-1:0]                req_tdata = '0;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [RSP_BITS-1:0]                rsp_tdata;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic                               csr_write_en = 1'b0;
   logic [seqi_pkg::CAPACITY_BITS-1:0] csr_write_data = '0;

   sorted_event_queue_insert u_top (
      .clock          (clock),
      .reset          (reset),
      .req_tdata      (req_tdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #4 clock = ~clock;

   // Our own copy of the sorted store and the capacity register.
   logic [15:0]                        sorted_times [DEPTH];
   logic [9:0]                         sorted_values [DEPTH];
   int                                 sorted_count = 0;
   logic [seqi_pkg::CAPACITY_BITS-1:0] capacity_setting = seqi_pkg::CAPACITY_RESET;

   logic [REQ_BITS-1:0] pending_events [$];
   insert_result_type   expected_results [$];
   insert_result_type   want_result;

   int  req_idle_pct = 13;
   int  rsp_idle_pct = 13;
   bit  req_beat_taken = 1'b0;
   bit  rsp_hold_request = 1'b0;
   int  rsp_hold_left = 0;
   int  error_count = 0;
   int  beats_checked = 0;
   int  inserted_beats = 0;
   int  refused_beats = 0;
   int  peak_fill = 0;

   function automatic insert_result_type predict_insert(logic [15:0] t, logic [9:0] v);
      insert_result_type r;
      int limit;
      int slot;
      limit = (capacity_setting < DEPTH) ? int'(capacity_setting) : DEPTH;
      r.dropped  = 1'b0;
      r.position = '0;
      if (sorted_count >= limit) begin
         r.dropped = 1'b1;
      end else begin
         // Walk past every entry that is not greater than the new key.
         slot = 0;
         while (slot < sorted_count &&
                !(t < sorted_times[slot] ||
                  (t == sorted_times[slot] && v < sorted_values[slot])))
            slot++;
         for (int i = sorted_count; i > slot; i--) begin
            sorted_times[i]  = sorted_times[i-1];
            sorted_values[i] = sorted_values[i-1];
         end
         sorted_times[slot]  = t;
         sorted_values[slot] = v;
         sorted_count++;
         r.position = 8'(slot + 1);
      end
      r.front_time  = (sorted_count > 0) ? sorted_times[0] : '0;
      r.front_value = (sorted_count > 0) ? sorted_values[0] : '0;
      r.count       = 8'(sorted_count);
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Request side: note accepted beats at the rising edge, drive at the falling edge.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         expected_results.push_back(predict_insert(req_tdata[15:0], req_tdata[25:16]));
         req_beat_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_beat_taken) begin
         req_beat_taken = 1'b0;
         if (pending_events.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
            req_tdata  <= pending_events.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response side: compare every beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("response beat with no insert outstanding");
            error_count++;
         end else begin
            want_result = expected_results.pop_front();
            check_field("dropped", want_result.dropped, rsp_tdata[0]);
            check_field("insert_position", want_result.position, rsp_tdata[8:1]);
            check_field("earliest_time", want_result.front_time, rsp_tdata[24:9]);
            check_field("earliest_value", want_result.front_value, rsp_tdata[34:25]);
            check_field("entry_count", want_result.count, rsp_tdata[42:35]);
            beats_checked++;
            if (want_result.dropped) refused_beats++;
            else inserted_beats++;
            if (want_result.count > peak_fill) peak_fill = want_result.count;
         end
      end
   end

   always @(negedge clock) begin
      if (rsp_hold_request) begin
         rsp_hold_left = 300;
         rsp_hold_request = 1'b0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic queue_event(logic [15:0] t, logic [9:0] v);
      pending_events.push_back({6'b0, v, t});
   endtask

   // Checked at the rising edge, where the driven signals are settled.
   task automatic wait_idle();
      while (pending_events.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_capacity(logic [seqi_pkg::CAPACITY_BITS-1:0] value);
      wait_idle();
      repeat (4) @(negedge clock);
      csr_write_data <= value;
      csr_write_en   <= 1'b1;
      @(negedge clock);
      csr_write_en <= 1'b0;
      capacity_setting = value;
   endtask

   initial begin
      logic [seqi_pkg::CAPACITY_BITS-1:0] phase_caps [8] =
         '{8'd12, 8'd3, 8'd40, 8'd100, 8'd127, 8'd128, 8'd255, 8'd200};
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Capacity zero refuses everything, and the empty queue reports a zero front.
      set_capacity(8'd0);
      queue_event(16'd0, 10'd0);
      queue_event(16'hFFFF, 10'h3FF);

      // A single slot: the second insert is refused but sees the first as front.
      set_capacity(8'd1);
      queue_event(16'd100, 10'd5);
      queue_event(16'd100, 10'd5);

      // Equal times sort by value; the extremes land at each end.
      set_capacity(8'd6);
      queue_event(16'd100, 10'd5);
      queue_event(16'd100, 10'd4);
      queue_event(16'd100, 10'd6);
      queue_event(16'd0, 10'd0);
      queue_event(16'hFFFF, 10'h3FF);
      queue_event(16'd50, 10'd50);
      queue_event(16'd0, 10'h3FF);

      for (int p = 0; p < 8; p++) begin
         set_capacity(phase_caps[p]);
         req_idle_pct = (p == 3) ? 0 : 13;
         rsp_idle_pct = (p == 3) ? 0 : 13;
         if (p == 6) rsp_hold_request = 1'b1;
         for (int n = 0; n < 235; n++) begin
            case ($urandom_range(3))
               0, 1: queue_event(16'($urandom_range(20)), 10'($urandom_range(3)));
               2: queue_event(16'($urandom), 10'($urandom));
               default: queue_event($urandom_range(1) ? 16'hFFFF : 16'd0,
                                    10'($urandom));
            endcase
         end
      end

      wait_idle();
      repeat (140) @(negedge clock);
      $display("tb_top summary: %0d beats checked, %0d inserted, %0d refused",
               beats_checked, inserted_beats, refused_beats);
      $display("tb_top summary: peak fill %0d entries over capacities 0 to 255", peak_fill);
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      #20000000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
